/* rtl/core/nsp_pkg.sv */
`timescale 1ns / 1ps
// shared widths, reset values, codes and controller/datapath bundles of the needle positioner
package nsp_pkg;

    localparam int unsigned READING_W  = 16;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned DZ_W       = 15;
    localparam int unsigned DIR_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // divider: 32-bit dividend, 16-bit divisor, two quotient bits per cycle
    localparam int unsigned DIV_NUM_W  = 32;
    localparam int unsigned DIV_DEN_W  = 16;
    localparam int unsigned DIV_STEPS  = 2;
    localparam int unsigned DIV_CYC    = DIV_NUM_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYC);

    localparam logic [READING_W-1:0]     RST_READING_MIN = 16'h0000;
    localparam logic [READING_W-1:0]     RST_READING_MAX = 16'hFFFF;
    localparam logic signed [POS_W-1:0]  RST_STEPS_AT_MIN = -16'sd256;
    localparam logic signed [POS_W-1:0]  RST_STEPS_AT_MAX = 16'sd256;
    localparam logic [DZ_W-1:0]          RST_DEADZONE = 15'd34;

    localparam logic [DIV_NUM_W-1:0]     PERIOD_NUMER = 32'd1000000;
    localparam logic [PERIOD_W-1:0]      PERIOD_SAT   = 16'hFFFF;

    localparam logic signed [DIR_W-1:0]  DIR_NONE = 2'sb00;
    localparam logic signed [DIR_W-1:0]  DIR_FWD  = 2'sb01;
    localparam logic signed [DIR_W-1:0]  DIR_BWD  = 2'sb11;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READING_MIN  = 3'd0,
        CFG_READING_MAX  = 3'd1,
        CFG_STEPS_AT_MIN = 3'd2,
        CFG_STEPS_AT_MAX = 3'd3,
        CFG_DEADZONE     = 3'd4
    } t_cfg_idx;

    // at most one command per controller state
    typedef struct packed {
        logic load_in;
        logic tick;
        logic map;
        logic mul;
        logic div1_start;
        logic tgt;
        logic div2_start;
        logic commit;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic op_tick;
        logic eq_lim;
        logic div_done;
    } t_sts;

endpackage

/* rtl/core/nsp_in_if.sv */
`timescale 1ns / 1ps
// input channel: valid/ready with op, reading and timer value
interface nsp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [nsp_pkg::READING_W-1:0]    reading;
    logic [nsp_pkg::TIME_W-1:0]       now_us;

    modport source (output valid, output op, output reading, output now_us, input ready);
    modport sink   (input valid, input op, input reading, input now_us, output ready);
endinterface

/* rtl/core/nsp_out_if.sv */
`timescale 1ns / 1ps
// result channel: valid/ready with step, motor state, period and position
interface nsp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [nsp_pkg::DIR_W-1:0]   step_dir;
    logic                               motor_on;
    logic [nsp_pkg::PERIOD_W-1:0]       step_period;
    logic signed [nsp_pkg::POS_W-1:0]   needle_pos;

    modport source (output valid, output step_dir, output motor_on, output step_period,
                    output needle_pos, input ready);
    modport sink   (input valid, input step_dir, input motor_on, input step_period,
                    input needle_pos, output ready);
endinterface

/* rtl/core/nsp_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine: sequences the datapath and owns the handshakes
module nsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nsp_pkg::t_cmd  o_cmd,
    input  nsp_pkg::t_sts  i_sts
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_TICK   = 11'b000_0000_0010,
        S_MAP    = 11'b000_0000_0100,
        S_MUL    = 11'b000_0000_1000,
        S_DV1S   = 11'b000_0001_0000,
        S_DV1W   = 11'b000_0010_0000,
        S_TGT    = 11'b000_0100_0000,
        S_DV2S   = 11'b000_1000_0000,
        S_DV2W   = 11'b001_0000_0000,
        S_COMMIT = 11'b010_0000_0000,
        S_PUSH   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.op_tick ? S_TICK : S_MAP;
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state = S_PUSH;
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                // equal limits: target is the low end, no map division
                n_state = i_sts.eq_lim ? S_TGT : S_DV1S;
            end
            S_DV1S: begin
                o_cmd.div1_start = 1'b1;
                n_state = S_DV1W;
            end
            S_DV1W: begin
                if (i_sts.div_done) begin
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                o_cmd.tgt = 1'b1;
                n_state = S_DV2S;
            end
            S_DV2S: begin
                o_cmd.div2_start = 1'b1;
                n_state = S_DV2W;
            end
            S_DV2W: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/nsp_div.sv */
`timescale 1ns / 1ps
// unsigned restoring divider, two quotient bits per cycle
module nsp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [nsp_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [nsp_pkg::DIV_DEN_W-1:0]    i_den,
    output logic [nsp_pkg::DIV_NUM_W-1:0]    o_quo,
    output logic                             o_done
);

    localparam int unsigned NW    = nsp_pkg::DIV_NUM_W;
    localparam int unsigned DW    = nsp_pkg::DIV_DEN_W;
    localparam int unsigned AW    = NW + DW;
    localparam int unsigned CW    = nsp_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(nsp_pkg::DIV_CYC - 1);

    // remainder in the top bits, dividend shifting out / quotient shifting in below
    logic [AW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                               input logic [DW-1:0] den);
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem;
        trial = {acc[AW-1:NW], acc[NW-1]};
        ge    = (trial >= {1'b0, den});
        rem   = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        return {rem, acc[NW-2:0], ge};
    endfunction

    always_comb begin
        n_acc = r_acc;
        for (int k = 0; k < nsp_pkg::DIV_STEPS; k++) begin
            n_acc = div_step(n_acc, r_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{DW{1'b0}}, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_quo  = r_acc[NW-1:0];
    assign o_done = r_done;

endmodule

/* rtl/core/nsp_dp.sv */
`timescale 1ns / 1ps
// datapath: configuration, needle state, reading map, period and stepping
module nsp_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [nsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nsp_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                 i_op,
    input  logic [nsp_pkg::READING_W-1:0]        i_reading,
    input  logic [nsp_pkg::TIME_W-1:0]           i_now_us,
    input  nsp_pkg::t_cmd                        i_cmd,
    output nsp_pkg::t_sts                        o_sts,
    output logic signed [nsp_pkg::DIR_W-1:0]     o_step_dir,
    output logic                                 o_motor_on,
    output logic [nsp_pkg::PERIOD_W-1:0]         o_step_period,
    output logic signed [nsp_pkg::POS_W-1:0]     o_needle_pos
);

    localparam int unsigned RW = nsp_pkg::READING_W;
    localparam int unsigned PW = nsp_pkg::POS_W;

    // configuration
    logic [RW-1:0]              r_rd_min, r_rd_max;
    logic signed [PW-1:0]       r_st_min, r_st_max;
    logic [nsp_pkg::DZ_W-1:0]   r_dz;

    // needle state
    logic signed [PW-1:0]               r_pos, r_tgt;
    logic [nsp_pkg::PERIOD_W-1:0]       r_period;
    logic [nsp_pkg::TIME_W-1:0]         r_last;
    logic                               r_en;

    // item and intermediates
    logic                               r_op;
    logic [RW-1:0]                      r_reading;
    logic [nsp_pkg::TIME_W-1:0]         r_now;
    logic signed [nsp_pkg::DIR_W-1:0]   r_dir;
    logic [RW-1:0]                      r_amag, r_smag, r_dmag;
    logic                               r_nsign, r_eq;
    logic [nsp_pkg::DIV_NUM_W-1:0]      r_prod;
    logic signed [PW-1:0]               r_nt;
    logic [PW-1:0]                      r_dist;

    // result register
    logic signed [nsp_pkg::DIR_W-1:0]   r_o_dir;
    logic                               r_o_en;
    logic [nsp_pkg::PERIOD_W-1:0]       r_o_period;
    logic signed [PW-1:0]               r_o_pos;

    function automatic logic [RW-1:0] mag17(input logic [RW:0] v);
        return v[RW] ? RW'(-v) : v[RW-1:0];
    endfunction

    // clamp and linear map operands
    logic [RW-1:0] w_x;
    logic [RW:0]   w_a, w_den, w_span;

    always_comb begin
        if (r_reading < r_rd_min) begin
            w_x = r_rd_min;
        end else if (r_reading > r_rd_max) begin
            w_x = r_rd_max;
        end else begin
            w_x = r_reading;
        end
        w_a    = {1'b0, w_x} - {1'b0, r_rd_min};
        w_den  = {1'b0, r_rd_max} - {1'b0, r_rd_min};
        w_span = {r_st_max[PW-1], r_st_max} - {r_st_min[PW-1], r_st_min};
    end

    // divider shared by the map quotient and the step period
    logic                               w_div_start;
    logic [nsp_pkg::DIV_NUM_W-1:0]      w_div_num, w_quo;
    logic [nsp_pkg::DIV_DEN_W-1:0]      w_div_den;
    logic                               w_div_done;

    assign w_div_start = i_cmd.div1_start | i_cmd.div2_start;
    assign w_div_num   = i_cmd.div1_start ? r_prod : nsp_pkg::PERIOD_NUMER;
    assign w_div_den   = i_cmd.div1_start ? r_dmag : r_dist;

    nsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // new target and distance from the current position
    logic [PW-1:0]        w_qmag, w_q;
    logic signed [PW-1:0] w_nt;
    logic [PW:0]          w_d;

    always_comb begin
        w_qmag = r_eq ? '0 : w_quo[PW-1:0];
        w_q    = r_nsign ? PW'(-w_qmag) : w_qmag;
        w_nt   = $signed(PW'(w_q + r_st_min));
        w_d    = {w_nt[PW-1], w_nt} - {r_pos[PW-1], r_pos};
    end

    // period and acceptance
    logic                           w_accept;
    logic [nsp_pkg::PERIOD_W-1:0]   w_period;

    always_comb begin
        w_accept = (r_dist >= {1'b0, r_dz});
        if (r_dist == '0 || (|w_quo[nsp_pkg::DIV_NUM_W-1:nsp_pkg::PERIOD_W])) begin
            w_period = nsp_pkg::PERIOD_SAT;
        end else begin
            w_period = w_quo[nsp_pkg::PERIOD_W-1:0];
        end
    end

    // tick step decision
    logic [nsp_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_step;
    logic                       w_fwd;

    assign w_elapsed = r_now - r_last;
    assign w_step    = r_en && (r_tgt != r_pos) && (w_elapsed >= r_period);
    assign w_fwd     = (r_tgt > r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_min <= nsp_pkg::RST_READING_MIN;
            r_rd_max <= nsp_pkg::RST_READING_MAX;
            r_st_min <= nsp_pkg::RST_STEPS_AT_MIN;
            r_st_max <= nsp_pkg::RST_STEPS_AT_MAX;
            r_dz     <= nsp_pkg::RST_DEADZONE;
            r_pos    <= '0;
            r_tgt    <= '0;
            r_period <= '0;
            r_last   <= '0;
            r_en     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    nsp_pkg::CFG_READING_MIN:  r_rd_min <= i_cfg_wdata[RW-1:0];
                    nsp_pkg::CFG_READING_MAX:  r_rd_max <= i_cfg_wdata[RW-1:0];
                    nsp_pkg::CFG_STEPS_AT_MIN: r_st_min <= $signed(i_cfg_wdata[PW-1:0]);
                    nsp_pkg::CFG_STEPS_AT_MAX: r_st_max <= $signed(i_cfg_wdata[PW-1:0]);
                    nsp_pkg::CFG_DEADZONE:     r_dz <= i_cfg_wdata[nsp_pkg::DZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                if (w_accept) begin
                    r_tgt    <= r_nt;
                    r_period <= w_period;
                    r_last   <= r_now;
                    r_en     <= 1'b1;
                end else begin
                    r_en <= 1'b0;
                end
            end
            if (i_cmd.tick && w_step) begin
                r_pos  <= w_fwd ? r_pos + 1'b1 : r_pos - 1'b1;
                r_last <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_op;
            r_reading <= i_reading;
            r_now     <= i_now_us;
            r_dir     <= nsp_pkg::DIR_NONE;
        end
        if (i_cmd.tick) begin
            r_dir <= w_step ? (w_fwd ? nsp_pkg::DIR_FWD : nsp_pkg::DIR_BWD)
                            : nsp_pkg::DIR_NONE;
        end
        if (i_cmd.map) begin
            r_amag  <= mag17(w_a);
            r_smag  <= mag17(w_span);
            r_dmag  <= mag17(w_den);
            r_nsign <= w_a[RW] ^ w_span[RW] ^ w_den[RW];
            r_eq    <= (r_rd_min == r_rd_max);
        end
        if (i_cmd.mul) begin
            r_prod <= r_amag * r_smag;
        end
        if (i_cmd.tgt) begin
            r_nt   <= w_nt;
            r_dist <= mag17(w_d);
        end
        if (i_cmd.push) begin
            r_o_dir    <= (r_op == nsp_pkg::OP_TICK) ? r_dir : nsp_pkg::DIR_NONE;
            r_o_en     <= r_en;
            r_o_period <= r_period;
            r_o_pos    <= r_pos;
        end
    end

    assign o_sts.op_tick  = (i_op == nsp_pkg::OP_TICK);
    assign o_sts.eq_lim   = r_eq;
    assign o_sts.div_done = w_div_done;

    assign o_step_dir    = r_o_dir;
    assign o_motor_on    = r_o_en;
    assign o_step_period = r_o_period;
    assign o_needle_pos  = r_o_pos;

endmodule

/* rtl/core/needle_stepper_positioner.sv */
`timescale 1ns / 1ps
// top level of the stepper needle positioner: controller, datapath and channel handshakes
//
//  channel   direction  handshake               payload
//  i_cmd     in         valid / ready           op, reading, now_us
//  o_res     out        valid / ready           step_dir, motor_on, step_period, needle_pos
//  cfg       in         i_cfg_wr_en (no wait)   i_cfg_index, i_cfg_wdata
//
// one item in flight; a tick item passes through the tick and push states before the next ready
// a set-target item makes two passes through the shared divider (two quotient bits
// per cycle) plus map, multiply and commit steps;
// with equal reading limits the first division is skipped
// the result register lets a new item be taken while the last result waits;
// a finished item stalls only if that register is still full
// reset is synchronous and restores the configuration defaults and needle state
module needle_stepper_positioner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    nsp_in_if.sink                                i_cmd,
    nsp_out_if.source                             o_res,
    input  logic                                  i_cfg_wr_en,
    input  logic [nsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [nsp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    // command and status bundles between controller and datapath
    nsp_pkg::t_cmd w_cmd;
    nsp_pkg::t_sts w_sts;

    // controller: sequencing plus input ready and result valid
    nsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath: config registers, needle state, divider and result register
    nsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_cmd.op),
        .i_reading     (i_cmd.reading),
        .i_now_us      (i_cmd.now_us),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_step_dir    (o_res.step_dir),
        .o_motor_on    (o_res.motor_on),
        .o_step_period (o_res.step_period),
        .o_needle_pos  (o_res.needle_pos)
    );

`ifndef SYNTHESIS
    // each controller state issues at most one command
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

    // a result is loaded only when the result register is free or draining
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten");

    // one item at a time: the block is busy right after an input transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("input taken while an item is in flight");

    // a step is only ever reported with the motor enabled
    a_step_needs_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.step_dir != nsp_pkg::DIR_NONE) |-> o_res.motor_on)
        else $error("step reported with motor disabled");
`endif

endmodule
